### src/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned EventW   = 3;
  localparam logic [ByteW-1:0]  PrefixByte   = 8'hFF;
  localparam logic [TicksW-1:0] TimeoutReset = 16'd10000;

  typedef enum logic [EventW-1:0] {
    EV_PAYLOAD   = 3'd0,
    EV_GOOD      = 3'd1,
    EV_BADSUM    = 3'd2,
    EV_TIMEOUT   = 3'd3,
    EV_MALFORMED = 3'd4
  } sfr_event_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [ByteW-1:0]  payload_byte;
    logic [ByteW-1:0]  frame_opcode;
    logic [ByteW-1:0]  device_number;
    logic [ByteW-1:0]  frame_length;
    logic              last;
  } sfr_res_t;

endpackage
`default_nettype wire

### src/sfr_channels.sv
`timescale 1ns / 1ps
`default_nettype none
interface sfr_item_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface sfr_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] payload_byte;
  logic [7:0] frame_opcode;
  logic [7:0] device_number;
  logic [7:0] frame_length;
  logic       last;
  modport source (output valid, event_res, payload_byte, frame_opcode, device_number,
                  frame_length, last, input ready);
  modport sink   (input valid, event_res, payload_byte, frame_opcode, device_number,
                  frame_length, last, output ready);
endinterface

interface sfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;
  modport source (output valid, timeout_ticks, input ready);
  modport sink   (input valid, timeout_ticks, output ready);
endinterface
`default_nettype wire

### src/serial_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// A request accepted on items is held in the input register; its result is loaded into the
// result register once that register has space, and is offered on results from there.
// One request per cycle unless results stall; a request with no result is not held.
// Reset (rst, synchronous): empties both registers, returns the deframer to hunting
// with all frame state zero, and loads the timeout with 10000 ticks.
module serial_frame_receiver (
  input  wire logic    clk,
  input  wire logic    rst,
  sfr_cfg_if.sink      cfg,
  sfr_item_if.sink     items,
  sfr_result_if.source results
);
  import sfr_pkg::*;

  logic             s0_valid;
  logic             s0_mode;
  logic [ByteW-1:0] s0_byte;
  logic             s0_go;
  logic             res_valid;
  logic             out_space;
  sfr_res_t         res;

  assign cfg.ready   = 1'b1;
  assign s0_go       = s0_valid && (!res_valid || out_space);
  assign items.ready = !s0_valid || s0_go;

  // Capture the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (items.ready) begin
      s0_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      s0_mode <= items.mode;
      s0_byte <= items.rx_byte;
    end
  end

  sfr_deframe u_deframe (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.timeout_ticks),
    .item_go   (s0_go),
    .item_mode (s0_mode),
    .item_byte (s0_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfr_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .push     (s0_go && res_valid),
    .push_res (res),
    .space    (out_space),
    .results  (results)
  );

`ifndef SYNTHESIS
  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.last == (results.event_res != EV_PAYLOAD)))
    else $error("last flag disagrees with event code");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.event_res <= EV_MALFORMED))
    else $error("event code out of range");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.event_res != EV_PAYLOAD)) |-> (results.payload_byte == '0))
    else $error("payload byte set on a frame-end result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready && s0_valid && res_valid) |-> !s0_go)
    else $error("request advanced over a stalled result");
`endif

endmodule
`default_nettype wire

### src/sfr_deframe.sv
`timescale 1ns / 1ps
`default_nettype none
module sfr_deframe (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [sfr_pkg::TicksW-1:0] cfg_data,
  input  wire logic                       item_go,
  input  wire logic                       item_mode,
  input  wire logic [sfr_pkg::ByteW-1:0]  item_byte,
  output logic                            res_valid,
  output sfr_pkg::sfr_res_t               res
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_OPCODE  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DEVICE  = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  phase_t            phase, phase_next;
  logic              saw_prefix, saw_prefix_next;
  logic [ByteW-1:0]  opcode_reg, opcode_reg_next;
  logic [ByteW-1:0]  length_reg, length_reg_next;
  logic [ByteW-1:0]  bytes_left, bytes_left_next;
  logic [ByteW-1:0]  running_sum, running_sum_next;
  logic [ByteW-1:0]  device_reg, device_reg_next;
  logic [TicksW-1:0] idle_ticks, idle_ticks_next;
  logic [TicksW-1:0] timeout_ticks;
  logic [TicksW:0]   tick_count;
  logic [ByteW-1:0]  left_dec;
  logic              frame_clear;
  logic              in_frame;

  assign tick_count = {1'b0, idle_ticks} + {{TicksW{1'b0}}, 1'b1};
  assign left_dec   = bytes_left - {{(ByteW-1){1'b0}}, 1'b1};
  assign in_frame   = (phase == PH_OPCODE) || (phase == PH_LENGTH) ||
                      (phase == PH_PAYLOAD) || (phase == PH_DEVICE) ||
                      (phase == PH_CHECK);

  // Work out the next frame state and the result of the current item
  always_comb begin
    phase_next       = phase;
    saw_prefix_next  = saw_prefix;
    opcode_reg_next  = opcode_reg;
    length_reg_next  = length_reg;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    device_reg_next  = device_reg;
    idle_ticks_next  = idle_ticks;
    frame_clear      = 1'b0;
    res_valid        = 1'b0;
    res.event_res     = EV_PAYLOAD;
    res.payload_byte  = '0;
    res.frame_opcode  = opcode_reg;
    res.device_number = '0;
    res.frame_length  = length_reg;
    res.last          = 1'b0;

    if (item_mode) begin
      if (tick_count >= {1'b0, timeout_ticks}) begin
        idle_ticks_next = '0;
        frame_clear     = 1'b1;
        if (in_frame) begin
          res_valid     = 1'b1;
          res.event_res = EV_TIMEOUT;
          res.last      = 1'b1;
        end
      end else begin
        idle_ticks_next = tick_count[TicksW-1:0];
      end
    end else begin
      idle_ticks_next = '0;
      unique case (phase)
        PH_OPCODE: begin
          opcode_reg_next  = item_byte;
          running_sum_next = item_byte;
          phase_next       = PH_LENGTH;
        end
        PH_LENGTH: begin
          length_reg_next  = item_byte;
          running_sum_next = running_sum + item_byte;
          bytes_left_next  = item_byte - 8'd2;
          if (item_byte < 8'd2) begin
            // short length: report with the length just taken, then hunt
            res_valid        = 1'b1;
            res.event_res    = EV_MALFORMED;
            res.frame_length = item_byte;
            res.last         = 1'b1;
            frame_clear      = 1'b1;
          end else if (item_byte == 8'd2) begin
            phase_next = PH_DEVICE;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_sum_next = running_sum + item_byte;
          bytes_left_next  = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_DEVICE;
          end
          res_valid        = 1'b1;
          res.event_res    = EV_PAYLOAD;
          res.payload_byte = item_byte;
        end
        PH_DEVICE: begin
          device_reg_next  = item_byte;
          running_sum_next = running_sum + item_byte;
          phase_next       = PH_CHECK;
        end
        PH_CHECK: begin
          res_valid         = 1'b1;
          res.event_res     = (item_byte == running_sum) ? EV_GOOD : EV_BADSUM;
          res.device_number = device_reg;
          res.last          = 1'b1;
          frame_clear       = 1'b1;
        end
        default: begin
          // hunt for two prefix bytes in a row
          if ((item_byte == PrefixByte) && saw_prefix) begin
            frame_clear = 1'b1;
          end else begin
            phase_next      = PH_HUNT;
            saw_prefix_next = (item_byte == PrefixByte);
          end
        end
      endcase
    end

    if (frame_clear) begin
      phase_next       = PH_HUNT;
      saw_prefix_next  = 1'b0;
      opcode_reg_next  = '0;
      length_reg_next  = '0;
      bytes_left_next  = '0;
      running_sum_next = '0;
      device_reg_next  = '0;
      if (!item_mode && (phase != PH_CHECK) && (phase != PH_LENGTH)) begin
        phase_next = PH_OPCODE;
      end
    end
  end

  // Hold frame state and the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      saw_prefix    <= 1'b0;
      opcode_reg    <= '0;
      length_reg    <= '0;
      bytes_left    <= '0;
      running_sum   <= '0;
      device_reg    <= '0;
      idle_ticks    <= '0;
      timeout_ticks <= TimeoutReset;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_data;
      end
      if (item_go) begin
        phase       <= phase_next;
        saw_prefix  <= saw_prefix_next;
        opcode_reg  <= opcode_reg_next;
        length_reg  <= length_reg_next;
        bytes_left  <= bytes_left_next;
        running_sum <= running_sum_next;
        device_reg  <= device_reg_next;
        idle_ticks  <= idle_ticks_next;
      end
    end
  end

endmodule
`default_nettype wire

### src/sfr_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
module sfr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sfr_pkg::sfr_res_t push_res,
  output logic                   space,
  sfr_result_if.source           results
);
  import sfr_pkg::*;

  logic     out_valid;
  sfr_res_t out_res;

  assign space = !out_valid || results.ready;

  // Load a new result when the slot is free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (space && push) begin
      out_res <= push_res;
    end
  end

  assign results.valid         = out_valid;
  assign results.event_res     = out_res.event_res;
  assign results.payload_byte  = out_res.payload_byte;
  assign results.frame_opcode  = out_res.frame_opcode;
  assign results.device_number = out_res.device_number;
  assign results.frame_length  = out_res.frame_length;
  assign results.last          = out_res.last;

endmodule
`default_nettype wire

### tb/serial_frame_receiver_tb.sv
`timescale 1ns / 1ps
module serial_frame_receiver_tb;
  import sfr_pkg::*;

  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned ReportLimit  = 10;

  typedef enum logic [2:0] {
    HUNT,
    GET_OPCODE,
    GET_LENGTH,
    GET_PAYLOAD,
    GET_DEVICE,
    GET_CHECK
  } deframe_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfr_cfg_if    cfg_ch ();
  sfr_item_if   item_ch ();
  sfr_result_if res_ch ();

  serial_frame_receiver i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .items   (item_ch),
    .results (res_ch)
  );

  // Deframer state as the block should hold it
  logic [15:0]    timeout_q;
  deframe_phase_t phase_q;
  logic           saw_ff_q;
  logic [7:0]     opcode_q;
  logic [7:0]     length_q;
  logic [7:0]     left_q;
  logic [7:0]     csum_q;
  logic [7:0]     device_q;
  logic [15:0]    idle_q;

  sfr_res_t    expected_results[$];
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  bit          gaps_on    = 1'b1;

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_frame();
    phase_q  = HUNT;
    saw_ff_q = 1'b0;
    opcode_q = 8'h00;
    length_q = 8'h00;
    left_q   = 8'h00;
    csum_q   = 8'h00;
    device_q = 8'h00;
  endfunction

  function automatic void push_result(sfr_event_t ev, logic [7:0] pay, logic [7:0] dev);
    sfr_res_t r;
    r.event_res     = ev;
    r.payload_byte  = pay;
    r.frame_opcode  = opcode_q;
    r.device_number = dev;
    r.frame_length  = length_q;
    r.last          = (ev != EV_PAYLOAD);
    expected_results.push_back(r);
  endfunction

  // Advance the deframer by one accepted request, queue any result it gives
  function automatic void deframe_step(logic m, logic [7:0] b);
    logic [16:0] next_idle;
    if (m) begin
      next_idle = {1'b0, idle_q} + 17'd1;
      if (next_idle >= {1'b0, timeout_q}) begin
        idle_q = 16'h0000;
        if (phase_q != HUNT) push_result(EV_TIMEOUT, 8'h00, 8'h00);
        clear_frame();
      end else begin
        idle_q = next_idle[15:0];
      end
    end else begin
      idle_q = 16'h0000;
      case (phase_q)
        GET_OPCODE: begin
          opcode_q = b;
          csum_q   = b;
          phase_q  = GET_LENGTH;
        end
        GET_LENGTH: begin
          length_q = b;
          csum_q   = csum_q + b;
          if (b < 8'd2) begin
            push_result(EV_MALFORMED, 8'h00, 8'h00);
            clear_frame();
          end else begin
            left_q  = b - 8'd2;
            phase_q = (left_q == 8'd0) ? GET_DEVICE : GET_PAYLOAD;
          end
        end
        GET_PAYLOAD: begin
          csum_q = csum_q + b;
          left_q = left_q - 8'd1;
          if (left_q == 8'd0) phase_q = GET_DEVICE;
          push_result(EV_PAYLOAD, b, 8'h00);
        end
        GET_DEVICE: begin
          device_q = b;
          csum_q   = csum_q + b;
          phase_q  = GET_CHECK;
        end
        GET_CHECK: begin
          push_result((b == csum_q) ? EV_GOOD : EV_BADSUM, 8'h00, device_q);
          clear_frame();
        end
        default: begin
          if (b == PrefixByte && saw_ff_q) begin
            clear_frame();
            phase_q = GET_OPCODE;
          end else begin
            phase_q  = HUNT;
            saw_ff_q = (b == PrefixByte);
          end
        end
      endcase
    end
  endfunction

  // Stall the result side at random
  always @(negedge clk) begin
    res_ch.ready = !(gaps_on && $urandom_range(99) < 33);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    sfr_res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        if (fail_count < ReportLimit)
          $display("unexpected result: ev=%0d pay=%02h op=%02h dev=%02h len=%02h last=%0b",
                   res_ch.event_res, res_ch.payload_byte, res_ch.frame_opcode,
                   res_ch.device_number, res_ch.frame_length, res_ch.last);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.event_res !== want.event_res || res_ch.payload_byte !== want.payload_byte ||
            res_ch.frame_opcode !== want.frame_opcode ||
            res_ch.device_number !== want.device_number ||
            res_ch.frame_length !== want.frame_length || res_ch.last !== want.last) begin
          if (fail_count < ReportLimit)
            $display({"mismatch at %0t: expected ev=%0d pay=%02h op=%02h dev=%02h len=%02h",
                      " last=%0b, got ev=%0d pay=%02h op=%02h dev=%02h len=%02h last=%0b"},
                     $time, want.event_res, want.payload_byte, want.frame_opcode,
                     want.device_number, want.frame_length, want.last,
                     res_ch.event_res, res_ch.payload_byte, res_ch.frame_opcode,
                     res_ch.device_number, res_ch.frame_length, res_ch.last);
          fail_count++;
        end
      end
    end
  end

  // Abort a run that hangs
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("serial_frame_receiver_tb: errors");
    $finish;
  end

  // Offer one request, hold it until accepted, then predict it
  task automatic send_item(input logic m, input logic [7:0] b);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(99) < 33) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid   = 1'b1;
    item_ch.mode    = m;
    item_ch.rx_byte = b;
    do @(posedge clk); while (!item_ch.ready);
    deframe_step(m, b);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b);
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Drop valid and hold until every expected result is in
  task automatic drain_results();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] t);
    drain_results();
    @(negedge clk);
    cfg_ch.valid         = 1'b1;
    cfg_ch.timeout_ticks = t;
    do @(posedge clk); while (!cfg_ch.ready);
    timeout_q = t;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Full frame with random payload and device; ticks sprinkled between bytes
  task automatic send_frame(input logic [7:0] op, input logic [7:0] len, input bit good_sum,
                            input int unsigned tick_pct);
    logic [7:0] csum;
    logic [7:0] b;
    send_byte(PrefixByte);
    send_byte(PrefixByte);
    send_byte(op);
    send_byte(len);
    csum = op + len;
    if (len >= 8'd2) begin
      for (int i = 0; i < int'(len) - 1; i++) begin
        if ($urandom_range(99) < tick_pct) send_tick();
        b    = 8'($urandom);
        csum = csum + b;
        send_byte(b);
      end
      send_byte(good_sum ? csum : csum ^ 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_directed_frames();
    // extreme payload bytes, zero opcode and device
    send_bytes('{8'hFF, 8'hFF, 8'h00, 8'h04, 8'h00, 8'hFF, 8'h00, 8'h03});
    // third prefix byte taken as opcode, no payload
    send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'h02, 8'hFF, 8'h00});
    // lengths one and zero are malformed
    send_bytes('{8'hFF, 8'hFF, 8'h12, 8'h01, 8'hFF, 8'hFF, 8'h34, 8'h00});
    // broken prefix, then a frame with a tick inside and a bad checksum
    send_bytes('{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h56, 8'h02});
    send_tick();
    send_bytes('{8'h9A, 8'h00});
  endtask

  // Ticks well below the reset timeout keep the frame alive
  task automatic test_reset_timeout();
    send_bytes('{8'hFF, 8'hFF, 8'h21});
    repeat (20) send_tick();
    send_bytes('{8'h02, 8'h5C, 8'h7F});
  endtask

  task automatic test_timeout_extremes();
    // zero acts like one: every tick times out
    write_timeout(16'd0);
    send_bytes('{8'hFF, 8'hFF, 8'h30});
    send_tick();
    send_tick();
    send_bytes('{8'hFF, 8'hFF, 8'h31, 8'h05, 8'h11});
    send_tick();
    write_timeout(16'd1);
    send_bytes('{8'hFF, 8'hFF, 8'h40, 8'h03, 8'hAA});
    send_tick();
    write_timeout(16'hFFFF);
    send_bytes('{8'hFF, 8'hFF, 8'h50});
    repeat (40) send_tick();
    send_bytes('{8'h02, 8'h00, 8'h52});
  endtask

  task automatic test_longest_frame();
    send_frame(8'hA5, 8'd255, 1'b1, 0);
    send_frame(8'h5A, 8'd255, 1'b0, 2);
  endtask

  // Mostly well-formed frames, some noise, cut frames and tick bursts
  task automatic test_random_traffic(input logic [15:0] tmo, input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    write_timeout(tmo);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(19))
          0:       len = $urandom_range(1);
          1:       len = $urandom_range(11, 60);
          default: len = $urandom_range(2, 10);
        endcase
        send_frame(8'($urandom), 8'(len), $urandom_range(3) != 0, 10);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4))
          send_byte($urandom_range(1) ? PrefixByte : 8'($urandom));
      end else if (pick < 90) begin
        len = $urandom_range(2, 10);
        send_bytes('{PrefixByte, PrefixByte, 8'($urandom), 8'(len)});
        cut = $urandom_range(len - 1);
        repeat (cut) send_byte(8'($urandom));
        if (timeout_q <= 16'd200)
          repeat ((timeout_q == 16'd0) ? 1 : int'(timeout_q)) send_tick();
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 8)) send_tick();
      end else begin
        drain_results();
      end
    end
  endtask

  task automatic test_no_stall_stream();
    gaps_on = 1'b0;
    test_random_traffic(16'd3, 250);
    gaps_on = 1'b1;
  endtask

  initial begin
    item_ch.valid        = 1'b0;
    item_ch.mode         = 1'b0;
    item_ch.rx_byte      = 8'h00;
    cfg_ch.valid         = 1'b0;
    cfg_ch.timeout_ticks = 16'h0000;
    res_ch.ready         = 1'b0;
    timeout_q            = TimeoutReset;
    idle_q               = 16'h0000;
    clear_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_frames();
    test_reset_timeout();
    test_timeout_extremes();
    test_longest_frame();
    test_no_stall_stream();
    test_random_traffic(16'd1, 175);
    test_random_traffic(16'd7, 175);
    test_random_traffic(16'd40, 175);
    test_random_traffic(16'hFFFF, 175);
    test_random_traffic(16'd0, 100);

    drain_results();
    if (fail_count == 0 && expected_results.size() == 0)
      $display("serial_frame_receiver_tb: clean");
    else
      $display("serial_frame_receiver_tb: errors");
    $finish;
  end

endmodule

### sim.f
src/sfr_pkg.sv
src/sfr_channels.sv
src/sfr_deframe.sv
src/sfr_out_reg.sv
src/serial_frame_receiver.sv
tb/serial_frame_receiver_tb.sv
